/* rtl/route_split_dp_macros.svh */
// assertion macros for the route split block
`ifndef ROUTE_SPLIT_DP_MACROS_SVH
`define ROUTE_SPLIT_DP_MACROS_SVH

// implication checked in the same cycle
`define RSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define RSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rsd_pkg.sv */
// shared constants and control structs for the route split block
package rsd_pkg;
  localparam int MAXC   = 64;
  localparam int POS_W  = $clog2(MAXC + 1);
  localparam int IDX_W  = $clog2(MAXC);
  localparam int DEM_W  = 16;
  localparam int DIST_W = 24;
  localparam int LOAD_W = DEM_W + 1;
  localparam int COST_W = DIST_W + IDX_W;
  localparam int RC_W   = 31;
  localparam int PATH_W = 37;
  localparam int TOT_W  = 36;
  localparam int IN_W   = DEM_W + 2 * DIST_W;
  localparam int OUT_RAW_W = 2 * 7 + RC_W + TOT_W;
  localparam int OUT_W  = ((OUT_RAW_W + 7) / 8) * 8;

  typedef struct packed {
    logic in_ready;
    logic start;
    logic emit_inf;
    logic o_rd;
    logic o_set;
    logic d_rd;
    logic d_acc;
    logic d_ev;
    logic next_i;
    logic bt_init;
    logic bt_rd;
    logic bt_rdp;
    logic bt_emit;
  } cmd_t;

  typedef struct packed {
    logic run_req;
    logic infeas;
    logic brk;
    logic j_last;
    logic i_last;
    logic p_zero;
    logic out_free;
  } sts_t;
endpackage

/* rtl/rsd_ctrl.sv */
// sequencer for loading, the split programme and the backtrack
module rsd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  rsd_pkg::sts_t sts,
  output rsd_pkg::cmd_t cmd
);
  import rsd_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_ORD, S_OSET, S_DRD, S_DACC, S_DEV, S_BTRD, S_BTRDP, S_BTOUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        if (sts.run_req) state_next = S_START;
      end
      S_START: begin
        if (sts.infeas) begin
          if (sts.out_free) begin
            cmd.emit_inf = 1'b1;
            state_next = S_LOAD;
          end
        end else begin
          cmd.start = 1'b1;
          state_next = S_ORD;
        end
      end
      S_ORD: begin
        cmd.o_rd = 1'b1;
        state_next = S_OSET;
      end
      S_OSET: begin
        cmd.o_set = 1'b1;
        state_next = S_DRD;
      end
      S_DRD: begin
        cmd.d_rd = 1'b1;
        state_next = S_DACC;
      end
      S_DACC: begin
        if (sts.brk) begin
          cmd.next_i = 1'b1;
          if (sts.i_last) begin
            cmd.bt_init = 1'b1;
            state_next = S_BTRD;
          end else begin
            state_next = S_ORD;
          end
        end else begin
          cmd.d_acc = 1'b1;
          state_next = S_DEV;
        end
      end
      S_DEV: begin
        cmd.d_ev = 1'b1;
        if (sts.j_last) begin
          cmd.next_i = 1'b1;
          if (sts.i_last) begin
            cmd.bt_init = 1'b1;
            state_next = S_BTRD;
          end else begin
            state_next = S_ORD;
          end
        end else begin
          state_next = S_DRD;
        end
      end
      S_BTRD: begin
        cmd.bt_rd = 1'b1;
        state_next = S_BTRDP;
      end
      S_BTRDP: begin
        cmd.bt_rdp = 1'b1;
        state_next = S_BTOUT;
      end
      S_BTOUT: begin
        if (sts.out_free) begin
          cmd.bt_emit = 1'b1;
          state_next = sts.p_zero ? S_LOAD : S_BTRD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* rtl/rsd_dp.sv */
// datapath: customer stores, programme tables, counters and output register
module rsd_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  rsd_pkg::cmd_t              cmd,
  output rsd_pkg::sts_t              sts,
  input  logic                       cfg_valid,
  input  logic [15:0]                cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rsd_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rsd_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast,
  output logic                       m_tuser
);
  import rsd_pkg::*;

  logic [DEM_W-1:0]  dem_mem  [MAXC];
  logic [DIST_W-1:0] dep_mem  [MAXC];
  logic [DIST_W-1:0] leg_mem  [MAXC];
  logic [PATH_W-1:0] cost_mem [MAXC+1];
  logic [POS_W-1:0]  pred_mem [MAXC+1];
  logic [MAXC:0]     reached;

  logic [DEM_W-1:0]  cap;
  logic [IDX_W-1:0]  cnt;
  logic [DEM_W-1:0]  maxdem;
  logic [POS_W-1:0]  n, i, j, p, oj;
  logic [LOAD_W-1:0] load;
  logic [COST_W-1:0] cost;
  logic [RC_W-1:0]   routec;
  logic [PATH_W-1:0] base, cj, total, cost_rd;
  logic [POS_W-1:0]  pred_rd;
  logic [DEM_W-1:0]  dem_rd;
  logic [DIST_W-1:0] dep_rd, leg_rd;
  logic              first_bt;

  logic [6:0]        o_first, o_end;
  logic [RC_W-1:0]   o_rc;
  logic [TOT_W-1:0]  o_tot;

  logic              accept;
  logic [DEM_W-1:0]  in_dem;
  logic [DEM_W-1:0]  dem_hi;
  logic [POS_W-1:0]  jm1, im1, p_guard, cost_addr;
  logic [LOAD_W-1:0] load_new;
  logic [COST_W-1:0] cost_new;
  logic [PATH_W-1:0] cand;
  logic              cost_re;

  assign s_tready = cmd.in_ready;
  assign accept   = s_tvalid && cmd.in_ready;
  assign in_dem   = s_tdata[DEM_W-1:0];
  assign dem_hi   = (cnt == '0 || in_dem > maxdem) ? in_dem : maxdem;
  assign jm1      = j - POS_W'(1);
  assign im1      = i - POS_W'(1);
  assign p_guard  = (pred_rd >= j) ? '0 : pred_rd;
  assign load_new = load + LOAD_W'(dem_rd);
  assign cost_new = (j == i) ? COST_W'(dep_rd) : cost + COST_W'(leg_rd);
  assign cand     = base + PATH_W'(routec);
  assign cost_re  = cmd.o_rd || cmd.d_rd || cmd.bt_rd || cmd.bt_rdp;

  always_comb begin
    cost_addr = j;
    if (cmd.o_rd)   cost_addr = im1;
    if (cmd.bt_rdp) cost_addr = p_guard;
  end

  assign sts.run_req  = accept && (s_tlast || cnt == IDX_W'(MAXC - 1));
  assign sts.infeas   = maxdem > cap;
  assign sts.brk      = load_new > LOAD_W'(cap);
  assign sts.j_last   = (j == n);
  assign sts.i_last   = (i == n);
  assign sts.p_zero   = (p == '0);
  assign sts.out_free = !m_tvalid || m_tready;

  // customer stores
  always_ff @(posedge clk) begin
    if (accept) begin
      dem_mem[cnt] <= in_dem;
      dep_mem[cnt] <= s_tdata[DEM_W +: DIST_W];
      leg_mem[cnt] <= s_tdata[DEM_W+DIST_W +: DIST_W];
    end
    if (cmd.d_rd) begin
      dem_rd <= dem_mem[jm1[IDX_W-1:0]];
      dep_rd <= dep_mem[jm1[IDX_W-1:0]];
      leg_rd <= leg_mem[jm1[IDX_W-1:0]];
    end
  end

  // programme tables, position zero reads as zero cost
  always_ff @(posedge clk) begin
    if (cmd.d_ev && (!reached[j] || cand < cost_rd)) begin
      cost_mem[j] <= cand;
      pred_mem[j] <= im1;
    end
    if (cost_re) begin
      cost_rd <= (cost_addr == '0) ? '0 : cost_mem[cost_addr];
    end
    if (cmd.bt_rd) begin
      pred_rd <= pred_mem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= '1;
      cnt      <= '0;
      reached  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) cap <= cfg_data;
      if (accept) begin
        maxdem <= dem_hi;
        if (sts.run_req) begin
          cnt <= '0;
          n   <= POS_W'(cnt) + POS_W'(1);
        end else begin
          cnt <= cnt + IDX_W'(1);
        end
      end
      if (cmd.start) begin
        reached <= '0;
        i       <= POS_W'(1);
      end
      if (cmd.o_set) begin
        base <= cost_rd;
        j    <= i;
        load <= '0;
      end
      if (cmd.d_acc) begin
        load   <= load_new;
        cost   <= cost_new;
        routec <= RC_W'(cost_new) + RC_W'(dep_rd);
      end
      if (cmd.d_ev) begin
        if (!reached[j] || cand < cost_rd) reached[j] <= 1'b1;
        j <= j + POS_W'(1);
      end
      if (cmd.next_i) i <= i + POS_W'(1);
      if (cmd.bt_init) begin
        j        <= n;
        first_bt <= 1'b1;
      end
      if (cmd.bt_rdp) begin
        p        <= p_guard;
        oj       <= j;
        cj       <= cost_rd;
        first_bt <= 1'b0;
        if (first_bt) total <= cost_rd;
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.emit_inf) begin
        m_tvalid <= 1'b1;
        o_first  <= '0;
        o_end    <= '0;
        o_rc     <= '0;
        o_tot    <= '0;
        m_tuser  <= 1'b1;
        m_tlast  <= 1'b1;
      end
      if (cmd.bt_emit) begin
        m_tvalid <= 1'b1;
        o_first  <= 7'(p) + 7'd1;
        o_end    <= 7'(oj);
        o_rc     <= RC_W'(cj - cost_rd);
        o_tot    <= total[TOT_W-1:0];
        m_tuser  <= 1'b0;
        m_tlast  <= (p == '0);
        j        <= p;
      end
    end
  end

  assign m_tdata = {(OUT_W - OUT_RAW_W)'(0), o_tot, o_rc, o_end, o_first};
endmodule

/* rtl/route_split_dp.sv */
// route split block: giant tour in, optimal capacity-limited routes out
// customers arrive on the s_ group one word each, in tour order; s_tlast marks
// the final customer, and the sixty-fourth customer closes the tour anyway.
// loading takes customers back to back. after the last one the programme
// runs one start position at a time: it reads the best cost up to that start,
// then for each end position adds the customer's demand and leg and keeps the
// cheaper path to that end, until the load would pass capacity. the backtrack
// then gives one word per route on the m_ group, last route first, m_tlast on
// the route that starts the tour. when some demand is above vehicle_capacity
// a single word with tuser set is given instead. the output word sits in a
// register; a stalled receiver only holds the backtrack or the infeasible
// word, and the next tour is taken as soon as the last route is in that
// register. cfg writes set vehicle_capacity and are always taken; write it
// only between tours. reset sets capacity to 65535 and empties the tour; the
// tables hold no reset value and need no clearing pass.
module route_split_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [15:0]                cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // customer_demand, dist_from_depot, dist_from_previous
  input  logic [rsd_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // route_first, route_end, route_cost, total_cost, zero fill
  output logic [rsd_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast,
  // infeasible
  output logic                       m_tuser
);
  import rsd_pkg::*;
  `include "route_split_dp_macros.svh"

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rsd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  `RSD_ASSERT_NOW(a_inf_final, m_tvalid && m_tuser, m_tlast && m_tdata[13:0] == 14'd0, "infeasible word not final")
  `RSD_ASSERT_NOW(a_route_order, m_tvalid && !m_tuser, m_tdata[6:0] != 7'd0 && m_tdata[6:0] <= m_tdata[13:7], "route bounds out of order")
  `RSD_ASSERT_NEXT(a_emit_loads, cmd.bt_emit || cmd.emit_inf, m_tvalid, "emitted word not held")
endmodule
